/* rtl/button_gesture_detector_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the button gesture detector
// Expect clk and rst in scope at the point of use.
// ----------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_DETECTOR_TOP_MACROS_SVH
`define BUTTON_GESTURE_DETECTOR_TOP_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define BGD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define BGD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bgd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_pkg
// Shared constants, codes and control types of the button gesture detector.
// ----------------------------------------------------------------------------
package bgd_pkg;

  localparam int NUM_KEYS    = 5;
  localparam int PIN_BITS    = 5;
  localparam int KEY_W       = 3;
  localparam int KEY_CNT_W   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int TIME_W      = 32;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int MAX_EVENTS  = 10;
  localparam int EVT_IDX_W   = $clog2(MAX_EVENTS);
  localparam int EVT_CNT_W   = $clog2(MAX_EVENTS + 1);

  localparam logic [CFG_W-1:0] TICK_PERIOD_RST   = 16'd25;
  localparam logic [CFG_W-1:0] DOUBLE_WINDOW_RST = 16'd500;
  localparam logic [CFG_W-1:0] LONG_TIME_RST     = 16'd500;

  typedef enum logic [2:0] {
    EV_RELEASE      = 3'd0,
    EV_PRESS        = 3'd1,
    EV_CLICK        = 3'd2,
    EV_DOUBLE_CLICK = 3'd3,
    EV_LONG         = 3'd4,
    EV_DOUBLE_LONG  = 3'd5
  } event_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICK_PERIOD   = 2'd0,
    REG_DOUBLE_WINDOW = 2'd1,
    REG_LONG_TIME     = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                 latch;
    logic                 eval_key;
    logic [KEY_CNT_W-1:0] key;
    logic                 advance_time;
    logic                 load_out;
    logic [EVT_IDX_W-1:0] rd_idx;
    logic                 last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [EVT_CNT_W-1:0] evt_count;
    logic                 out_free;
  } dp_status_t;

endpackage

/* rtl/bgd_pin_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_pin_if
// Scan tick channel: one item carries the levels of all key pins.
// ----------------------------------------------------------------------------
interface bgd_pin_if import bgd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PIN_BITS-1:0] pin_levels;

  modport source (output valid, output pin_levels, input ready);
  modport sink   (input valid, input pin_levels, output ready);
endinterface

/* rtl/bgd_evt_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_evt_if
// Event channel: one item per key event.
// ----------------------------------------------------------------------------
interface bgd_evt_if import bgd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_index;
  logic [2:0]       event_code;
  logic             last_of_tick;

  modport source (output valid, output key_index, output event_code,
                  output last_of_tick, input ready);
  modport sink   (input valid, input key_index, input event_code,
                  input last_of_tick, output ready);
endinterface

/* rtl/bgd_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bgd_cfg_if import bgd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/button_gesture_detector_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_detector_top
// Press, release, click, double click, long press and double long press events per key from
// scan ticks of pulled-up key pins.
//
//   channel  dir  payload                                  item
//   pin_ch   in   pin_levels[4:0]                          one scan tick
//   evt_ch   out  key_index[2:0] event_code[2:0] last_of_tick  one event
//   cfg_ch   in   index[1:0] data[15:0]                    one register write
//
// A tick is accepted, then each key is evaluated in turn, then the event list is drained.
// Event drain waits on evt_ch.ready; the next tick is accepted while the
// last event of the previous one still sits in the output register.
// rst clears time, key state and config to reset values.
// cfg_ch is always ready; writes take effect on the next cycle.
// ----------------------------------------------------------------------------
`include "button_gesture_detector_top_macros.svh"

module button_gesture_detector_top import bgd_pkg::*; (
  input logic       clk,
  input logic       rst,
  bgd_pin_if.sink   pin_ch,
  bgd_evt_if.source evt_ch,
  bgd_cfg_if.sink   cfg_ch
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  bgd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pin_valid (pin_ch.valid),
    .pin_ready (pin_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  bgd_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .pin_levels (pin_ch.pin_levels),
    .evt_ch     (evt_ch),
    .cfg_ch     (cfg_ch)
  );

  `BGD_ASSERT_NEXT(a_accept_busy, pin_ch.valid && pin_ch.ready, !pin_ch.ready, "ready after accept")
  `BGD_ASSERT_SAME(a_no_overwrite, cmd.load_out, status.out_free, "pending event overwritten")
  `BGD_ASSERT_NEXT(a_last_to_idle, cmd.load_out && cmd.last, pin_ch.ready, "not idle after last")
  `BGD_ASSERT_SAME(a_idle_quiet, pin_ch.ready, !cmd.load_out && !cmd.eval_key, "work while idle")

endmodule

/* rtl/bgd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_ctrl
// Sequencer: walks the keys one per cycle, then drains the event list.
// ----------------------------------------------------------------------------
module bgd_ctrl import bgd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       pin_valid,
  output logic       pin_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_EMIT
  } state_t;

  state_t               state;
  logic [KEY_CNT_W-1:0] key_cnt;
  logic [EVT_IDX_W-1:0] rd_idx;
  logic                 last_key;
  logic                 emit_last;
  logic                 has_events;

  assign pin_ready  = (state == S_IDLE);
  assign last_key   = (key_cnt == KEY_CNT_W'(NUM_KEYS - 1));
  assign has_events = (status.evt_count != '0);
  assign emit_last  = (EVT_CNT_W'(rd_idx) == status.evt_count - EVT_CNT_W'(1));

  always_comb begin
    cmd              = '0;
    cmd.latch        = pin_valid && pin_ready;
    cmd.eval_key     = (state == S_EVAL);
    cmd.key          = key_cnt;
    cmd.advance_time = (state == S_EVAL) && last_key;
    cmd.load_out     = (state == S_EMIT) && has_events && status.out_free;
    cmd.rd_idx       = rd_idx;
    cmd.last         = emit_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      key_cnt <= '0;
      rd_idx  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (pin_valid) begin
            key_cnt <= '0;
            state   <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (last_key) begin
            rd_idx <= '0;
            state  <= S_EMIT;
          end else begin
            key_cnt <= key_cnt + KEY_CNT_W'(1);
          end
        end
        S_EMIT: begin
          if (!has_events) begin
            state <= S_IDLE;
          end else if (status.out_free) begin
            if (emit_last) begin
              state <= S_IDLE;
            end else begin
              rd_idx <= rd_idx + EVT_IDX_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/bgd_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_dp
// Datapath: config registers, time base, per-key state, event list and
// output register.
// ----------------------------------------------------------------------------
module bgd_dp import bgd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  ctrl_cmd_t           cmd,
  output dp_status_t          status,
  input  logic [PIN_BITS-1:0] pin_levels,
  bgd_evt_if.source           evt_ch,
  bgd_cfg_if.sink             cfg_ch
);

  logic [CFG_W-1:0]  tick_period;
  logic [CFG_W-1:0]  double_window;
  logic [CFG_W-1:0]  long_time;
  logic [TIME_W-1:0] time_now;

  logic [TIME_W-1:0] last_change [NUM_KEYS];
  logic [TIME_W-1:0] last_press  [NUM_KEYS];
  logic [NUM_KEYS-1:0] key_pressed;
  logic [NUM_KEYS-1:0] double_flag;
  logic [NUM_KEYS-1:0] long_reported;

  logic [PIN_BITS-1:0] pins_q;
  logic [NUM_KEYS-1:0] pins_ext;

  logic [KEY_W-1:0]     evt_key  [MAX_EVENTS];
  event_code_t          evt_code [MAX_EVENTS];
  logic [EVT_CNT_W-1:0] evt_count;

  logic             out_valid;
  logic [KEY_W-1:0] out_key;
  event_code_t      out_code;
  logic             out_last;

  logic              cur_pressed;
  logic [TIME_W-1:0] held;
  logic [TIME_W-1:0] since_press;
  logic              changed;
  logic              held_long;
  logic              cur_double;
  logic              ev_a_valid;
  logic              ev_b_valid;
  event_code_t       ev_a_code;
  event_code_t       ev_b_code;
  logic              wr_a;
  logic              wr_b;
  logic [EVT_CNT_W-1:0] idx_b;

  // keys past the pin field read as released
  always_comb begin
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (i < PIN_BITS) begin
        pins_ext[i] = pins_q[i];
      end else begin
        pins_ext[i] = 1'b1;
      end
    end
  end

  assign cur_pressed = ~pins_ext[cmd.key];
  assign held        = time_now - last_change[cmd.key];
  assign since_press = time_now - last_press[cmd.key];
  assign changed     = (cur_pressed != key_pressed[cmd.key]);
  assign held_long   = (held >= TIME_W'(long_time));
  assign cur_double  = double_flag[cmd.key];

  always_comb begin
    ev_a_valid = 1'b0;
    ev_a_code  = EV_RELEASE;
    ev_b_valid = 1'b0;
    ev_b_code  = EV_CLICK;
    if (changed) begin
      ev_a_valid = 1'b1;
      ev_a_code  = cur_pressed ? EV_PRESS : EV_RELEASE;
      if (!cur_pressed && !held_long) begin
        ev_b_valid = 1'b1;
        ev_b_code  = cur_double ? EV_DOUBLE_CLICK : EV_CLICK;
      end
    end else if (cur_pressed && held_long && !long_reported[cmd.key]) begin
      ev_a_valid = 1'b1;
      ev_a_code  = cur_double ? EV_DOUBLE_LONG : EV_LONG;
    end
  end

  // events past the list capacity are dropped
  assign wr_a  = cmd.eval_key && ev_a_valid && (evt_count < EVT_CNT_W'(MAX_EVENTS));
  assign idx_b = evt_count + EVT_CNT_W'(wr_a);
  assign wr_b  = cmd.eval_key && ev_b_valid && (idx_b < EVT_CNT_W'(MAX_EVENTS));

  // config registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period   <= TICK_PERIOD_RST;
      double_window <= DOUBLE_WINDOW_RST;
      long_time     <= LONG_TIME_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_TICK_PERIOD:   tick_period   <= cfg_ch.data;
        REG_DOUBLE_WINDOW: double_window <= cfg_ch.data;
        REG_LONG_TIME:     long_time     <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // time base and per-key state
  always_ff @(posedge clk) begin
    if (rst) begin
      time_now      <= '0;
      key_pressed   <= '0;
      double_flag   <= '0;
      long_reported <= '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        last_change[i] <= '0;
        last_press[i]  <= '0;
      end
    end else begin
      if (cmd.advance_time) begin
        time_now <= time_now + TIME_W'(tick_period);
      end
      if (cmd.eval_key) begin
        if (changed) begin
          if (cur_pressed) begin
            double_flag[cmd.key] <= (since_press < TIME_W'(double_window));
            last_press[cmd.key]  <= time_now;
          end else if (!held_long) begin
            double_flag[cmd.key] <= 1'b0;
          end
          last_change[cmd.key]   <= time_now;
          key_pressed[cmd.key]   <= cur_pressed;
          long_reported[cmd.key] <= 1'b0;
        end else if (cur_pressed && held_long && !long_reported[cmd.key]) begin
          double_flag[cmd.key]   <= 1'b0;
          long_reported[cmd.key] <= 1'b1;
        end
      end
    end
  end

  // event list
  always_ff @(posedge clk) begin
    if (rst) begin
      evt_count <= '0;
    end else if (cmd.latch) begin
      evt_count <= '0;
    end else if (cmd.eval_key) begin
      evt_count <= idx_b + EVT_CNT_W'(wr_b);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      pins_q <= pin_levels;
    end
    if (wr_a) begin
      evt_key[evt_count[EVT_IDX_W-1:0]]  <= KEY_W'(cmd.key);
      evt_code[evt_count[EVT_IDX_W-1:0]] <= ev_a_code;
    end
    if (wr_b) begin
      evt_key[idx_b[EVT_IDX_W-1:0]]  <= KEY_W'(cmd.key);
      evt_code[idx_b[EVT_IDX_W-1:0]] <= ev_b_code;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (evt_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_key  <= evt_key[cmd.rd_idx];
      out_code <= evt_code[cmd.rd_idx];
      out_last <= cmd.last;
    end
  end

  assign evt_ch.valid        = out_valid;
  assign evt_ch.key_index    = out_key;
  assign evt_ch.event_code   = out_code;
  assign evt_ch.last_of_tick = out_last;

  assign status.evt_count = evt_count;
  assign status.out_free  = !out_valid || evt_ch.ready;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for button_gesture_detector_top. Scan ticks go in
// through a queue-fed driver; a clocked monitor checks every key event
// against a local gesture predictor. Register settings change between
// phases, covering zero and full-scale values.
// ----------------------------------------------------------------------------
module testbench;
  import bgd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 24;

  typedef struct {
    logic [KEY_W-1:0] key;
    event_code_t      code;
    logic             last;
  } evt_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bgd_pin_if pin_ch();
  bgd_evt_if evt_ch();
  bgd_cfg_if cfg_ch();

  button_gesture_detector_top dut (
    .clk    (clk),
    .rst    (rst),
    .pin_ch (pin_ch),
    .evt_ch (evt_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #40_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // predictor copy of registers and key state
  logic [CFG_W-1:0]  tick_period;
  logic [CFG_W-1:0]  dbl_window;
  logic [CFG_W-1:0]  long_time;
  logic [TIME_W-1:0] now_ms;
  logic [TIME_W-1:0] change_ms [NUM_KEYS];
  logic [TIME_W-1:0] press_ms [NUM_KEYS];
  bit                key_down [NUM_KEYS];
  bit                dbl_armed [NUM_KEYS];
  bit                long_done [NUM_KEYS];

  logic [PIN_BITS-1:0] scan_queue [$];
  evt_rec_t            expected_events [$];

  bit quiet_mode = 1'b0;
  bit hold_pins  = 1'b0;
  bit pin_taken  = 1'b0;
  int pin_wait   = 0;
  int evt_wait   = 0;
  int mismatches = 0;
  int ticks_sent = 0;
  int events_seen = 0;
  int settings_used = 0;
  int code_seen [6];

  function automatic int idle_len();
    int r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic predict_tick(input logic [PIN_BITS-1:0] pins);
    evt_rec_t          evs [$];
    evt_rec_t          ev;
    logic [TIME_W-1:0] stamp;
    logic [TIME_W-1:0] held;
    bit                down;
    stamp = now_ms;
    for (int k = 0; k < NUM_KEYS; k++) begin
      down = (k < PIN_BITS) ? !pins[k] : 1'b0;
      held = stamp - change_ms[k];
      ev.key  = KEY_W'(k);
      ev.last = 1'b0;
      if (down != key_down[k]) begin
        ev.code = down ? EV_PRESS : EV_RELEASE;
        if (evs.size() < MAX_EVENTS) evs.push_back(ev);
        if (down) begin
          dbl_armed[k] = (stamp - press_ms[k]) < {16'd0, dbl_window};
          press_ms[k]  = stamp;
        end else if (held < {16'd0, long_time}) begin
          ev.code = dbl_armed[k] ? EV_DOUBLE_CLICK : EV_CLICK;
          if (evs.size() < MAX_EVENTS) evs.push_back(ev);
          dbl_armed[k] = 1'b0;
        end
        change_ms[k] = stamp;
        key_down[k]  = down;
        long_done[k] = 1'b0;
      end else if (down && held >= {16'd0, long_time} && !long_done[k]) begin
        ev.code = dbl_armed[k] ? EV_DOUBLE_LONG : EV_LONG;
        if (evs.size() < MAX_EVENTS) evs.push_back(ev);
        dbl_armed[k] = 1'b0;
        long_done[k] = 1'b1;
      end
    end
    if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
    foreach (evs[i]) expected_events.push_back(evs[i]);
    now_ms = stamp + {16'd0, tick_period};
  endtask

  task automatic check_event();
    evt_rec_t want;
    events_seen++;
    if (evt_ch.event_code < 6) code_seen[evt_ch.event_code]++;
    if (expected_events.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected event: key %0d code %0d last %0d",
                 evt_ch.key_index, evt_ch.event_code, evt_ch.last_of_tick);
    end else begin
      want = expected_events.pop_front();
      if (evt_ch.key_index !== want.key || evt_ch.event_code !== want.code ||
          evt_ch.last_of_tick !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("event %0d mismatch: expected key %0d code %0d last %0d",
                   events_seen, want.key, want.code, want.last);
          $display("  got key %0d code %0d last %0d",
                   evt_ch.key_index, evt_ch.event_code, evt_ch.last_of_tick);
        end
      end
    end
  endtask

  // accept side: check results first, then predict the tick taken at this edge
  always @(posedge clk) begin
    if (rst) begin
      pin_taken <= 1'b0;
    end else begin
      pin_taken <= pin_ch.valid && pin_ch.ready;
      if (evt_ch.valid && evt_ch.ready) check_event();
      if (pin_ch.valid && pin_ch.ready) begin
        ticks_sent++;
        predict_tick(pin_ch.pin_levels);
      end
    end
  end

  // scan tick driver
  always @(negedge clk) begin
    if (rst) begin
      pin_ch.valid <= 1'b0;
    end else if (!pin_ch.valid || pin_taken) begin
      if (pin_wait > 0) begin
        pin_wait--;
        pin_ch.valid <= 1'b0;
      end else if (!hold_pins && scan_queue.size() > 0) begin
        pin_ch.valid      <= 1'b1;
        pin_ch.pin_levels <= scan_queue.pop_front();
        pin_wait = idle_len();
      end else begin
        pin_ch.valid <= 1'b0;
      end
    end
  end

  // event sink stalls
  always @(negedge clk) begin
    if (rst) begin
      evt_ch.ready <= 1'b0;
    end else if (evt_wait > 0) begin
      evt_wait--;
      evt_ch.ready <= 1'b0;
    end else begin
      evt_ch.ready <= 1'b1;
      evt_wait = ($urandom_range(0, 3) == 0) ? idle_len() : 0;
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_TICK_PERIOD) tick_period = value;
    else if (idx == REG_DOUBLE_WINDOW) dbl_window = value;
    else if (idx == REG_LONG_TIME) long_time = value;
  endtask

  task automatic cfg_close();
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic apply_setting(input logic [CFG_W-1:0] tick, input logic [CFG_W-1:0] window,
                               input logic [CFG_W-1:0] hold);
    cfg_write(REG_TICK_PERIOD, tick);
    cfg_write(REG_DOUBLE_WINDOW, window);
    cfg_write(REG_LONG_TIME, hold);
    cfg_close();
  endtask

  // block goes quiet: all ticks taken, all events back, then a margin for
  // ticks that produce no event
  task automatic settle();
    do @(posedge clk);
    while (scan_queue.size() != 0 || pin_ch.valid || expected_events.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // press/hold/release patterns per key, timed around the long threshold,
  // with some fully random ticks mixed in
  task automatic gen_gestures(input int n);
    bit                  down [NUM_KEYS];
    int                  left [NUM_KEYS];
    int                  lt;
    int                  r;
    logic [PIN_BITS-1:0] p;
    lt = (tick_period == 0) ? 12 : long_time / tick_period;
    if (lt > 12) lt = 12;
    for (int k = 0; k < NUM_KEYS; k++) begin
      down[k] = 1'b0;
      left[k] = $urandom_range(0, 4);
    end
    repeat (n) begin
      p = '1;
      if ($urandom_range(0, 9) == 0) begin
        p = PIN_BITS'($urandom_range(0, 31));
      end else begin
        for (int k = 0; k < PIN_BITS; k++) begin
          if (left[k] <= 0) begin
            down[k] = !down[k];
            r = $urandom_range(0, 9);
            if (down[k])
              left[k] = (r < 5) ? $urandom_range(1, 2) :
                        (r < 8) ? lt + $urandom_range(0, 2) : $urandom_range(1, lt + 3);
            else
              left[k] = (r < 4) ? 1 : $urandom_range(2, 6);
            if (left[k] < 1) left[k] = 1;
          end
          left[k]--;
          p[k] = !down[k];
        end
      end
      scan_queue.push_back(p);
    end
  endtask

  initial begin
    int     ph_tick [6]  = '{25, 1, 65535, 10, 7, 100};
    int     ph_win [6]   = '{500, 65535, 1, 35, 65535, 250};
    int     ph_long [6]  = '{100, 3, 65535, 40, 1, 600};
    bit     ph_quiet [6] = '{0, 1, 0, 0, 0, 1};
    int     ph_len [6]   = '{25, 25, 20, 30, 20, 25};

    pin_ch.valid      = 1'b0;
    pin_ch.pin_levels = '1;
    evt_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_TICK_PERIOD;
    cfg_ch.data       = '0;
    tick_period = TICK_PERIOD_RST;
    dbl_window  = DOUBLE_WINDOW_RST;
    long_time   = LONG_TIME_RST;
    now_ms      = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      change_ms[k] = '0;
      press_ms[k]  = '0;
      key_down[k]  = 1'b0;
      dbl_armed[k] = 1'b0;
      long_done[k] = 1'b0;
    end
    foreach (code_seen[i]) code_seen[i] = 0;

    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // reset values: first press near time zero is a double, then all keys
    // at once, whose release makes a full tick of ten events
    scan_queue.push_back(5'h1E);
    scan_queue.push_back(5'h1F);
    scan_queue.push_back(5'h00);
    scan_queue.push_back(5'h1F);
    scan_queue.push_back(5'h15);
    scan_queue.push_back(5'h0A);
    scan_queue.push_back(5'h1F);
    settle();

    // held key reaches long press; write to an unused index is ignored
    cfg_write(REG_LONG_TIME, 16'd50);
    cfg_write(REG_UNUSED, 16'hFFFF);
    cfg_close();
    repeat (4) scan_queue.push_back(5'h1B);
    scan_queue.push_back(5'h1F);
    settle();

    // zero double window and zero long time
    cfg_write(REG_DOUBLE_WINDOW, 16'd0);
    cfg_write(REG_LONG_TIME, 16'd0);
    cfg_close();
    scan_queue.push_back(5'h0F);
    scan_queue.push_back(5'h0F);
    scan_queue.push_back(5'h1F);
    scan_queue.push_back(5'h0F);
    scan_queue.push_back(5'h1F);
    settle();

    // frozen time
    cfg_write(REG_TICK_PERIOD, 16'd0);
    cfg_close();
    scan_queue.push_back(5'h1E);
    scan_queue.push_back(5'h1E);
    scan_queue.push_back(5'h1F);
    settle();

    // long time dropped under a hold that never reported long
    apply_setting(16'd25, 16'd500, 16'd1000);
    scan_queue.push_back(5'h17);
    scan_queue.push_back(5'h17);
    settle();
    cfg_write(REG_LONG_TIME, 16'd20);
    cfg_close();
    scan_queue.push_back(5'h1F);
    scan_queue.push_back(5'h17);
    scan_queue.push_back(5'h1F);
    settle();

    for (int i = 0; i < 6; i++) begin
      apply_setting(CFG_W'(ph_tick[i]), CFG_W'(ph_win[i]), CFG_W'(ph_long[i]));
      quiet_mode = ph_quiet[i];
      gen_gestures(ph_len[i]);
      if (i == 3) begin
        do @(posedge clk); while (scan_queue.size() > ph_len[i] / 2);
        hold_pins = 1'b1;
        do @(posedge clk); while (pin_ch.valid || expected_events.size() != 0);
        hold_pins = 1'b0;
      end
      settle();
    end

    quiet_mode = 1'b0;
    gen_gestures(10);
    settle();

    mismatches += expected_events.size();
    $display("Covered %0d scan ticks and %0d events under %0d register settings.",
             ticks_sent, events_seen, settings_used);
    $display("Events: release %0d, press %0d, click %0d, double click %0d, long %0d",
             code_seen[0], code_seen[1], code_seen[2], code_seen[3], code_seen[4]);
    $display("        double long %0d", code_seen[5]);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
